### rtl/avlp_pkg.sv
// Shared types, constants and reset values for the averaged level to position decoder.
`timescale 1ns / 1ps

package avlp_pkg;

    localparam int NUM_THRESHOLDS      = 6;
    localparam int SAMPLES_PER_AVERAGE = 10;
    localparam int SAMPLE_BITS         = 12;

    // Fixed by the register map and the port fields
    localparam int THR_REGS = 6;
    localparam int LEVEL_W  = 12;
    localparam int POS_W    = 3;
    localparam int MARGIN_W = 8;
    localparam int IDX_W    = 3;
    localparam int DATA_W   = 12;

    // Accumulator and group counter
    localparam int SUM_W = SAMPLE_BITS + $clog2(SAMPLES_PER_AVERAGE);
    localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);

    // Floor divide by the group size: multiply by a rounded-up reciprocal and shift
    localparam int AVG_SHIFT = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int RECIP_W   = AVG_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'((2 ** AVG_SHIFT + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);

    // Register indexes beyond the thresholds
    localparam logic [IDX_W-1:0] REG_POS_COUNT = 3'd6;
    localparam logic [IDX_W-1:0] REG_HYST      = 3'd7;

    localparam logic [THR_REGS-1:0][LEVEL_W-1:0] THR_RESET = {
        12'd3510, 12'd2925, 12'd2340, 12'd1755, 12'd1170, 12'd585
    };
    localparam logic [POS_W-1:0]    POS_COUNT_RESET = 3'd6;
    localparam logic [MARGIN_W-1:0] HYST_RESET      = 8'd5;

    typedef struct packed {
        logic [THR_REGS-1:0][LEVEL_W-1:0] thr;
        logic [POS_W-1:0]                 pos_count;
        logic [MARGIN_W-1:0]              margin;
    } cfg_t;

endpackage

### rtl/avlp_cfg_regs.sv
// Configuration register file: thresholds, position count and hysteresis margin.
`timescale 1ns / 1ps

module avlp_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [avlp_pkg::IDX_W-1:0]  cfg_index,
    input  logic [avlp_pkg::DATA_W-1:0] cfg_data,
    output avlp_pkg::cfg_t             cfg
);
    import avlp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            priority if (32'(cfg_index) < THR_REGS) begin
                cfg_next.thr[cfg_index[$clog2(THR_REGS)-1:0]] = cfg_data[LEVEL_W-1:0];
            end else if (cfg_index == REG_POS_COUNT) begin
                cfg_next.pos_count = cfg_data[POS_W-1:0];
            end else if (cfg_index == REG_HYST) begin
                cfg_next.margin = cfg_data[MARGIN_W-1:0];
            end else begin
                cfg_next = cfg_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.thr       <= THR_RESET;
            cfg_reg.pos_count <= POS_COUNT_RESET;
            cfg_reg.margin    <= HYST_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/avlp_decoder.sv
// Level to position decoder with hysteresis around the current position.
`timescale 1ns / 1ps

module avlp_decoder (
    input  avlp_pkg::cfg_t              cfg,
    input  logic [avlp_pkg::POS_W-1:0]   cur_pos,
    input  logic [avlp_pkg::LEVEL_W-1:0] level,
    output logic [avlp_pkg::POS_W-1:0]   pos
);
    import avlp_pkg::*;

    logic [POS_W-1:0]   limit;
    logic [LEVEL_W:0]   eff [NUM_THRESHOLDS];
    logic [LEVEL_W:0]   thr_ext;
    logic [LEVEL_W:0]   margin_ext;

    assign margin_ext = (LEVEL_W+1)'(cfg.margin);
    assign limit = (cfg.pos_count > POS_W'(NUM_THRESHOLDS)) ? POS_W'(NUM_THRESHOLDS)
                                                             : cfg.pos_count;

    always_comb begin
        for (int i = 0; i < NUM_THRESHOLDS; i++) begin
            thr_ext = {1'b0, cfg.thr[i]};
            if (cur_pos != '0 && cur_pos - 1'b1 == POS_W'(i)) begin
                // threshold below the current position: lowered, floored at zero
                eff[i] = (thr_ext > margin_ext) ? thr_ext - margin_ext : '0;
            end else if (cur_pos == POS_W'(i)) begin
                eff[i] = thr_ext + margin_ext;
            end else begin
                eff[i] = thr_ext;
            end
        end
    end

    // first threshold not exceeded wins
    always_comb begin
        pos = limit;
        for (int i = NUM_THRESHOLDS - 1; i >= 0; i--) begin
            if (POS_W'(i) < limit && {1'b0, level} <= eff[i]) begin
                pos = POS_W'(i);
            end
        end
    end

endmodule

### rtl/averaged_level_to_position_top.sv
// Top level: sample averaging, position state and the result register.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | s_sample
//  m_      | out       | m_valid / m_ready    | m_position, m_position_changed,
//          |           |                      | m_average_done, m_mean_level
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One sample per cycle while s_ready is high; a result appears in the cycle after its sample beat.
// The accumulate, reciprocal multiply and threshold compares sit in combinational logic
// ahead of the result register.
// s_ready drops only while a result is held and m_ready is low.
// Reset (aresetn, synchronous) restores the register defaults; no clearing pass.
`timescale 1ns / 1ps

module averaged_level_to_position_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [11:0]                 s_sample,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [2:0]                  m_position,
    output logic                        m_position_changed,
    output logic                        m_average_done,
    output logic [11:0]                 m_mean_level,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [avlp_pkg::IDX_W-1:0]  cfg_index,
    input  logic [avlp_pkg::DATA_W-1:0] cfg_data
);
    import avlp_pkg::*;

    cfg_t cfg;

    logic               primed_reg,  primed_next;
    logic [SUM_W-1:0]   sum_reg,     sum_next;
    logic [CNT_W-1:0]   cnt_reg,     cnt_next;
    logic [POS_W-1:0]   cur_pos_reg, cur_pos_next;
    logic [LEVEL_W-1:0] mean_reg,    mean_next;

    logic               m_valid_reg, m_valid_next;
    logic [POS_W-1:0]   out_pos_reg;
    logic               out_changed_reg;
    logic               out_done_reg;
    logic [LEVEL_W-1:0] out_mean_reg;

    logic               accept;
    logic [LEVEL_W-1:0] samp;
    logic [SUM_W-1:0]   sum_add;
    logic [CNT_W-1:0]   cnt_inc;
    logic [PROD_W-1:0]  prod;
    logic [LEVEL_W-1:0] group_mean;
    logic               group_done;
    logic [LEVEL_W-1:0] dec_level;
    logic [POS_W-1:0]   dec_pos;
    logic               changed;

    avlp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign samp       = LEVEL_W'(s_sample[SAMPLE_BITS-1:0]);
    assign sum_add    = sum_reg + SUM_W'(samp);
    assign cnt_inc    = cnt_reg + 1'b1;
    assign group_done = primed_reg && (cnt_inc >= CNT_W'(SAMPLES_PER_AVERAGE));
    assign prod       = PROD_W'(sum_add) * PROD_W'(AVG_RECIP);
    assign group_mean = prod[AVG_SHIFT +: LEVEL_W];

    // first sample decodes directly, later ones decode the group mean
    assign dec_level = primed_reg ? group_mean : samp;

    avlp_decoder u_dec (
        .cfg     (cfg),
        .cur_pos (cur_pos_reg),
        .level   (dec_level),
        .pos     (dec_pos)
    );

    assign changed = group_done && (dec_pos != cur_pos_reg);

    always_comb begin
        primed_next  = primed_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        cur_pos_next = cur_pos_reg;
        mean_next    = mean_reg;
        if (accept) begin
            primed_next = 1'b1;
            if (!primed_reg) begin
                cur_pos_next = dec_pos;
            end else if (group_done) begin
                sum_next     = '0;
                cnt_next     = '0;
                mean_next    = group_mean;
                cur_pos_next = dec_pos;
            end else begin
                sum_next = sum_add;
                cnt_next = cnt_inc;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg  <= 1'b0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            cur_pos_reg <= '0;
            mean_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            primed_reg  <= primed_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            cur_pos_reg <= cur_pos_next;
            mean_reg    <= mean_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_pos_reg     <= cur_pos_next;
            out_changed_reg <= changed;
            out_done_reg    <= group_done;
            out_mean_reg    <= mean_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_position         = out_pos_reg;
    assign m_position_changed = out_changed_reg;
    assign m_average_done     = out_done_reg;
    assign m_mean_level       = out_mean_reg;

`ifndef SYNTHESIS
    a_change_needs_group: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!out_changed_reg || out_done_reg))
        else $error("position change reported without a finished group");

    a_beat_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted sample produced no result");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < CNT_W'(SAMPLES_PER_AVERAGE))
        else $error("group counter out of range");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_pos_reg <= POS_W'(NUM_THRESHOLDS))
        else $error("position beyond threshold count");
`endif

endmodule
